[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl modules of the marginal unit
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hw/rtl/wmd_pkg.sv]
// shared types and constants of the weighted marginal distribution unit
// no dependencies
package wmd_pkg;

  localparam int unsigned MaxRows  = 64;
  localparam int unsigned MaxCols  = 1024;
  localparam int unsigned RowW     = 6;
  localparam int unsigned ColW     = 10;
  localparam int unsigned SumW     = 48;
  localparam int unsigned ColWsumW = 22;
  localparam int unsigned RowWsumW = 26;
  localparam int unsigned TermW    = 32;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw   = 2;

  typedef enum logic [1:0] {
    REG_AXIS_MODE     = 2'd0,
    REG_WEIGHTED_MODE = 2'd1,
    REG_COLUMNS_USED  = 2'd2,
    REG_ROWS_USED     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic        axis_mode;
    logic        weighted_mode;
    logic [10:0] columns_used;
    logic [6:0]  rows_used;
  } cfg_t;

  // one marginal waiting to be finished by the back end
  typedef struct packed {
    logic [ColW-1:0]     bin;
    logic [SumW-1:0]     sum;
    logic [RowWsumW-1:0] wsum;
    logic                last;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE  = 2'd0,
    F_ACC   = 2'd1,
    F_SRD   = 2'd2,
    F_SPUSH = 2'd3
  } fstate_e;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_DIV  = 2'd1,
    B_DONE = 2'd2
  } bstate_e;

endpackage

[hw/rtl/weighted_marginal_distribution_unit.sv]
// Weighted marginal distribution unit: pixels in column-major order (row index
// fastest), one marginal per column (axis_mode 0) or one per row after the
// image's last pixel (axis_mode 1). A new pixel word is taken once the last
// has left the ACC state, for the read-modify-write of the row-sum memories.
// A frequency-mode image end sweeps the rows, reading (SRD) and pushing (SPUSH)
// each row. In unweighted mode, or when the energy sum is zero, a marginal goes
// straight to the output register; a weighted one passes the one-bit-per-cycle
// divider. A 4-deep job queue lets pixels keep flowing while the divider is
// busy. Row memories need no clearing pass: per-row valid bits drop at image
// start. Top level, depends on wmd_pkg, wmd_front, wmd_fifo, wmd_back, wmd_ram.
module weighted_marginal_distribution_unit
  import wmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // sample [15:0], weight [31:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // bin_index [9:0], marginal [57:10], zeros
  output logic        m_axis_tuser_o,   // zero_weight
  output logic        m_axis_tlast_o    // last_of_run
);

  cfg_t cfg_q, cfg_d;
  logic push, full, pop, empty;
  job_t push_job, pop_job;
  logic [ColW-1:0] bin;
  logic [SumW-1:0] marg;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_AXIS_MODE:     cfg_d.axis_mode     = cfg_data_i[0];
        REG_WEIGHTED_MODE: cfg_d.weighted_mode = cfg_data_i[0];
        REG_COLUMNS_USED:  cfg_d.columns_used  = cfg_data_i;
        REG_ROWS_USED:     cfg_d.rows_used     = cfg_data_i[6:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_mode     <= 1'b0;
      cfg_q.weighted_mode <= 1'b0;
      cfg_q.columns_used  <= 11'(MaxCols);
      cfg_q.rows_used     <= 7'(MaxRows);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (s_axis_tvalid_i),
    .pix_ready_o (s_axis_tready_o),
    .sample_i    (s_axis_tdata_i[15:0]),
    .weight_i    (s_axis_tdata_i[31:16]),
    .push_o      (push),
    .job_o       (push_job),
    .full_i      (full)
  );

  wmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  wmd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .weighted_i    (cfg_q.weighted_mode),
    .empty_i       (empty),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .bin_o         (bin),
    .marginal_o    (marg),
    .zero_weight_o (m_axis_tuser_o),
    .last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'd0, marg, bin};

endmodule

[hw/rtl/wmd_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module wmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/wmd_fifo.sv]
// short job queue between the accumulating front end and the dividing back end
// depends on wmd_pkg and assert_macros.svh
`include "assert_macros.svh"

module wmd_fifo
  import wmd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  job_t            mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FifoAw:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == FifoAw'(0) + (FifoAw+1)'(FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_fifo_overflow, push_i && full_o, "job pushed into full queue")
  `ASSERT_NEVER(a_fifo_underflow, pop_i && empty_o, "job popped from empty queue")

endmodule

[hw/rtl/wmd_front.sv]
// front end: takes pixels, accumulates column and row sums, queues marginal jobs
// depends on wmd_pkg and wmd_ram
module wmd_front
  import wmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        pix_valid_i,
  output logic        pix_ready_o,
  input  logic [15:0] sample_i,
  input  logic [15:0] weight_i,
  output logic        push_o,
  output job_t        job_o,
  input  logic        full_i
);

  fstate_e fstate_q, fstate_d;
  logic [RowW-1:0]     row_cnt_q, row_cnt_d;
  logic [ColW-1:0]     col_cnt_q, col_cnt_d;
  logic [SumW-1:0]     col_sum_q, col_sum_d;
  logic [ColWsumW-1:0] col_wsum_q, col_wsum_d;
  logic [TermW-1:0]    term_q;
  logic [15:0]         w_q;
  logic [MaxRows-1:0]  valid_q, valid_d;
  logic [RowW-1:0]     sweep_q, sweep_d;

  logic [6:0]          rows;
  logic [10:0]         cols;
  logic                accept;
  logic [32:0]         prod;
  logic [RowW-1:0]     raddr;
  logic                we;
  logic [SumW-1:0]     rsum_rd, rsum_old, rsum_new;
  logic [RowWsumW-1:0] rwsum_rd, rwsum_old, rwsum_new;
  logic [SumW-1:0]     term_ext;
  logic                end_col, end_img;

  // out-of-range sizes clamp to 1 or the maximum
  always_comb begin
    priority if (cfg_i.rows_used == '0) begin
      rows = 7'd1;
    end else if (cfg_i.rows_used > 7'(MaxRows)) begin
      rows = 7'(MaxRows);
    end else begin
      rows = cfg_i.rows_used;
    end
    priority if (cfg_i.columns_used == '0) begin
      cols = 11'd1;
    end else if (cfg_i.columns_used > 11'(MaxCols)) begin
      cols = 11'(MaxCols);
    end else begin
      cols = cfg_i.columns_used;
    end
  end

  assign pix_ready_o = (fstate_q == F_IDLE);
  assign accept      = pix_valid_i && pix_ready_o;
  assign prod        = $signed(sample_i) * $signed({1'b0, weight_i});
  assign raddr       = (fstate_q == F_SRD || fstate_q == F_SPUSH) ? sweep_q : row_cnt_q;

  wmd_ram #(.WIDTH(SumW), .DEPTH(MaxRows)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (row_cnt_q),
    .wdata_i (rsum_new),
    .raddr_i (raddr),
    .rdata_o (rsum_rd)
  );

  wmd_ram #(.WIDTH(RowWsumW), .DEPTH(MaxRows)) u_wsum_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (row_cnt_q),
    .wdata_i (rwsum_new),
    .raddr_i (raddr),
    .rdata_o (rwsum_rd)
  );

  // a row not yet written in this image reads as zero
  assign rsum_old  = valid_q[raddr] ? rsum_rd : '0;
  assign rwsum_old = valid_q[raddr] ? rwsum_rd : '0;
  assign term_ext  = {{(SumW-TermW){term_q[TermW-1]}}, term_q};
  assign rsum_new  = rsum_old + term_ext;
  assign rwsum_new = rwsum_old + RowWsumW'(w_q);
  assign end_col   = ({1'b0, row_cnt_q} + 7'd1) >= rows;
  assign end_img   = end_col && (({1'b0, col_cnt_q} + 11'd1) >= cols);

  always_comb begin
    fstate_d   = fstate_q;
    row_cnt_d  = row_cnt_q;
    col_cnt_d  = col_cnt_q;
    col_sum_d  = col_sum_q;
    col_wsum_d = col_wsum_q;
    valid_d    = valid_q;
    sweep_d    = sweep_q;
    we         = 1'b0;
    push_o     = 1'b0;
    job_o      = '0;
    unique case (fstate_q)
      F_IDLE: begin
        if (accept) begin
          if (row_cnt_q == '0 && col_cnt_q == '0) begin
            valid_d = '0;
          end
          fstate_d = F_ACC;
        end
      end
      F_ACC: begin
        col_sum_d  = ((row_cnt_q == '0) ? '0 : col_sum_q) + term_ext;
        col_wsum_d = ((row_cnt_q == '0) ? '0 : col_wsum_q) + ColWsumW'(w_q);
        job_o.bin  = col_cnt_q;
        job_o.sum  = col_sum_d;
        job_o.wsum = RowWsumW'(col_wsum_d);
        job_o.last = 1'b1;
        if (!(cfg_i.axis_mode == 1'b0 && end_col && full_i)) begin
          we                 = 1'b1;
          valid_d[row_cnt_q] = 1'b1;
          push_o             = (cfg_i.axis_mode == 1'b0) && end_col;
          if (end_col) begin
            row_cnt_d = '0;
            col_cnt_d = end_img ? '0 : col_cnt_q + 1'b1;
          end else begin
            row_cnt_d = row_cnt_q + 1'b1;
          end
          if (cfg_i.axis_mode && end_img) begin
            sweep_d  = '0;
            fstate_d = F_SRD;
          end else begin
            fstate_d = F_IDLE;
          end
        end else begin
          col_sum_d  = col_sum_q;
          col_wsum_d = col_wsum_q;
        end
      end
      F_SRD: begin
        fstate_d = F_SPUSH;
      end
      F_SPUSH: begin
        job_o.bin  = ColW'(sweep_q);
        job_o.sum  = rsum_old;
        job_o.wsum = rwsum_old;
        job_o.last = ({1'b0, sweep_q} + 7'd1) == rows;
        if (!full_i) begin
          push_o = 1'b1;
          if (job_o.last) begin
            fstate_d = F_IDLE;
          end else begin
            sweep_d  = sweep_q + 1'b1;
            fstate_d = F_SRD;
          end
        end
      end
      default: fstate_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fstate_q   <= F_IDLE;
      row_cnt_q  <= '0;
      col_cnt_q  <= '0;
      col_sum_q  <= '0;
      col_wsum_q <= '0;
      valid_q    <= '0;
      sweep_q    <= '0;
    end else begin
      fstate_q   <= fstate_d;
      row_cnt_q  <= row_cnt_d;
      col_cnt_q  <= col_cnt_d;
      col_sum_q  <= col_sum_d;
      col_wsum_q <= col_wsum_d;
      valid_q    <= valid_d;
      sweep_q    <= sweep_d;
    end
  end

  // product (the sample in unweighted mode) registered at accept, added to the sums in the ACC state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      term_q <= cfg_i.weighted_mode ? prod[TermW-1:0]
                                    : {{(TermW-16){sample_i[15]}}, sample_i};
      w_q    <= weight_i;
    end
  end

endmodule

[hw/rtl/wmd_back.sv]
// back end: turns queued sums into marginals, divides in weighted mode
// depends on wmd_pkg and assert_macros.svh
`include "assert_macros.svh"

module wmd_back
  import wmd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            weighted_i,
  input  logic            empty_i,
  input  job_t            job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [ColW-1:0] bin_o,
  output logic [SumW-1:0] marginal_o,
  output logic            zero_weight_o,
  output logic            last_o
);

  bstate_e bstate_q, bstate_d;
  logic [SumW-1:0]     dvd_q, dvd_d;
  logic [RowWsumW:0]   rem_q, rem_d;
  logic [RowWsumW-1:0] div_q, div_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                neg_q, neg_d;
  logic [ColW-1:0]     jbin_q, jbin_d;
  logic                jlast_q, jlast_d;
  logic                ovalid_q, ovalid_d;
  logic [ColW-1:0]     obin_q, obin_d;
  logic [SumW-1:0]     omarg_q, omarg_d;
  logic                ozw_q, ozw_d;
  logic                olast_q, olast_d;

  logic                out_free;
  logic [RowWsumW:0]   rem_sh;
  logic [RowWsumW+1:0] rem_sub;

  assign out_free = !ovalid_q || out_ready_i;
  // one quotient bit per cycle, restoring
  assign rem_sh   = {rem_q[RowWsumW-1:0], dvd_q[SumW-1]};
  assign rem_sub  = {1'b0, rem_sh} - {2'b00, div_q};

  always_comb begin
    bstate_d = bstate_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    div_d    = div_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    jbin_d   = jbin_q;
    jlast_d  = jlast_q;
    ovalid_d = ovalid_q && !out_ready_i;
    obin_d   = obin_q;
    omarg_d  = omarg_q;
    ozw_d    = ozw_q;
    olast_d  = olast_q;
    pop_o    = 1'b0;
    unique case (bstate_q)
      B_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          if (!weighted_i || job_i.wsum == '0) begin
            ovalid_d = 1'b1;
            obin_d   = job_i.bin;
            omarg_d  = weighted_i ? '0 : job_i.sum;
            ozw_d    = weighted_i;
            olast_d  = job_i.last;
          end else begin
            neg_d    = job_i.sum[SumW-1];
            dvd_d    = job_i.sum[SumW-1] ? -job_i.sum : job_i.sum;
            rem_d    = '0;
            div_d    = job_i.wsum;
            cnt_d    = '0;
            jbin_d   = job_i.bin;
            jlast_d  = job_i.last;
            bstate_d = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (!rem_sub[RowWsumW+1]) begin
          rem_d = rem_sub[RowWsumW:0];
          dvd_d = {dvd_q[SumW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          dvd_d = {dvd_q[SumW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'(SumW-1)) begin
          bstate_d = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obin_d   = jbin_q;
          omarg_d  = neg_q ? -dvd_q : dvd_q;
          ozw_d    = 1'b0;
          olast_d  = jlast_q;
          bstate_d = B_IDLE;
        end
      end
      default: bstate_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bstate_q <= B_IDLE;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      bstate_q <= bstate_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    neg_q   <= neg_d;
    jbin_q  <= jbin_d;
    jlast_q <= jlast_d;
    obin_q  <= obin_d;
    omarg_q <= omarg_d;
    ozw_q   <= ozw_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign bin_o         = obin_q;
  assign marginal_o    = omarg_q;
  assign zero_weight_o = ozw_q;
  assign last_o        = olast_q;

  `ASSERT_CLK(a_div_cnt_range, (bstate_q == B_DIV) |-> (cnt_q < 6'(SumW)),
              "divider ran past its last step")
  `ASSERT_CLK(a_div_nonzero, (bstate_q == B_DIV) |-> (div_q != '0),
              "divider started on a zero energy sum")

endmodule

[dv/weighted_marginal_distribution_unit_test.sv]
// self-checking bench for the weighted marginal distribution unit: random images in
// time and frequency mode, weighted and unweighted, checked against an in-bench predictor
// depends on wmd_pkg and weighted_marginal_distribution_unit
module weighted_marginal_distribution_unit_test;
  import wmd_pkg::*;

  typedef struct {
    bit [9:0]  bin;
    bit [47:0] marg;
    bit        zw;
    bit        last;
  } marginal_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  reg_idx_e    cfg_idx_i = REG_AXIS_MODE;
  logic [10:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // sample [15:0], weight [31:16]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;        // bin_index [9:0], marginal [57:10], zeros
  logic        m_axis_tuser_o;        // zero_weight
  logic        m_axis_tlast_o;        // last_of_run

  weighted_marginal_distribution_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  bit        axis_q, wmode_q;
  bit [10:0] cols_q = 11'd1024;
  bit [6:0]  rows_q = 7'd64;
  int        col_cnt, row_cnt;
  bit [47:0] col_sum;
  bit [21:0] col_wsum;
  bit [47:0] row_sum [MaxRows];
  bit [25:0] row_wsum [MaxRows];

  logic [31:0] pixel_q [$];
  marginal_t   marginal_q [$];
  int          errors, accepted;
  int          send_idle = 15, recv_idle = 50;
  bit          hold_off;

  function automatic marginal_t make_marginal(int bin, bit [47:0] sum, bit [25:0] wsum,
                                              bit last);
    marginal_t m;
    longint sx;
    m.bin = bin[9:0];
    m.marg = sum;
    m.zw = 1'b0;
    m.last = last;
    if (wmode_q) begin
      if (wsum == 0) begin
        m.marg = '0;
        m.zw = 1'b1;
      end else begin
        sx = {{16{sum[47]}}, sum};
        sx = sx / longint'(wsum);
        m.marg = sx[47:0];
      end
    end
    return m;
  endfunction

  function automatic void predict_pixel(logic [31:0] word);
    int rows, cols, r;
    longint s, term;
    bit end_col, end_img;
    rows = (rows_q == 0) ? 1 : (rows_q > MaxRows) ? MaxRows : rows_q;
    cols = (cols_q == 0) ? 1 : (cols_q > MaxCols) ? MaxCols : cols_q;
    r = (row_cnt < MaxRows) ? row_cnt : MaxRows - 1;
    if (row_cnt == 0 && col_cnt == 0) begin
      foreach (row_sum[k]) begin
        row_sum[k] = '0;
        row_wsum[k] = '0;
      end
    end
    if (row_cnt == 0) begin
      col_sum = '0;
      col_wsum = '0;
    end
    s = longint'($signed(word[15:0]));
    term = wmode_q ? s * longint'(word[31:16]) : s;
    col_sum += term[47:0];
    col_wsum += word[31:16];
    row_sum[r] += term[47:0];
    row_wsum[r] += word[31:16];
    end_col = (row_cnt + 1 >= rows);
    end_img = end_col && (col_cnt + 1 >= cols);
    if (!axis_q) begin
      if (end_col) marginal_q.push_back(make_marginal(col_cnt, col_sum, col_wsum, 1'b1));
    end else if (end_img) begin
      for (int k = 0; k < rows; k++)
        marginal_q.push_back(make_marginal(k, row_sum[k], row_wsum[k], k + 1 == rows));
    end
    if (end_col) begin
      row_cnt = 0;
      col_cnt = end_img ? 0 : col_cnt + 1;
    end else begin
      row_cnt++;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || s_axis_tready_o)) begin
      if (s_axis_tvalid_i) begin
        predict_pixel(s_axis_tdata_i);
        accepted++;
      end
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= pixel_q.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    marginal_t e;
    if (rst_ni) begin
      m_axis_tready_i <= !hold_off && ($urandom_range(99) >= recv_idle);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (marginal_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word bin %0d", m_axis_tdata_o[9:0]);
        end else begin
          e = marginal_q.pop_front();
          if (m_axis_tdata_o[9:0] !== e.bin || m_axis_tdata_o[57:10] !== e.marg ||
              m_axis_tuser_o !== e.zw || m_axis_tlast_o !== e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp bin %0d marg %0d zw %0b last %0b, got %0d %0d %0b %0b",
                       e.bin, $signed(e.marg), e.zw, e.last, m_axis_tdata_o[9:0],
                       $signed(m_axis_tdata_o[57:10]), m_axis_tuser_o, m_axis_tlast_o);
          end
        end
      end
    end
  end

  // idling schedule
  always @(posedge clk_i) begin
    if (accepted > 250) begin
      send_idle <= 0;
      recv_idle <= 0;
    end else if (accepted > 125) begin
      send_idle <= 50;
      recv_idle <= 15;
    end
  end

  // long receiver stall so the job queue fills and input backs up
  initial begin
    wait (accepted >= 60);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic wait_idle();
    wait (pixel_q.size() == 0 && !s_axis_tvalid_i && marginal_q.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, bit [10:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_AXIS_MODE:     axis_q = val[0];
      REG_WEIGHTED_MODE: wmode_q = val[0];
      REG_COLUMNS_USED:  cols_q = val;
      REG_ROWS_USED:     rows_q = val[6:0];
    endcase
  endtask

  task automatic set_config(bit axis, bit wm, bit [10:0] cols, bit [6:0] rows);
    wait_idle();
    write_reg(REG_AXIS_MODE, axis);
    write_reg(REG_WEIGHTED_MODE, wm);
    write_reg(REG_COLUMNS_USED, cols);
    write_reg(REG_ROWS_USED, rows);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_pixel(bit [15:0] smp, bit [15:0] wt);
    pixel_q.push_back({wt, smp});
  endtask

  initial begin
    int total, er, ec, npix;
    bit [10:0] c;
    bit [6:0] r;
    bit zero_img;
    bit [15:0] smp, wt;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // weighted per column: extremes, an all-zero-energy column, truncation of a fractional quotient
    set_config(1'b0, 1'b1, 11'd3, 7'd2);
    add_pixel(16'h7fff, 16'hffff);
    add_pixel(16'h7fff, 16'hffff);
    add_pixel(16'h8000, 16'h0000);
    add_pixel(16'h1234, 16'h0000);
    add_pixel(16'hffff, 16'd1);
    add_pixel(16'h0002, 16'd3);
    // weighted per row, second row with zero energy
    set_config(1'b1, 1'b1, 11'd2, 7'd2);
    add_pixel(16'h8000, 16'hffff);
    add_pixel(16'h0005, 16'h0000);
    add_pixel(16'hfff9, 16'd2);
    add_pixel(16'h7fff, 16'h0000);
    // unweighted per row, sizes of zero act as one
    set_config(1'b1, 1'b0, 11'd0, 7'd0);
    add_pixel(16'h8000, 16'hffff);
    add_pixel(16'h7fff, 16'h0000);
    // unweighted per column at the largest sizes out of range, one partial column
    set_config(1'b0, 1'b0, 11'd2047, 7'd127);
    for (int i = 0; i < 8; i++) add_pixel(16'h8000, 16'hffff);
    // one-row columns, a word per column, runs into the long receiver stall
    set_config(1'b0, 1'b0, 11'd1024, 7'd1);
    for (int i = 0; i < 60; i++) add_pixel(16'($urandom), 16'($urandom));
    total = 80;

    while (total < 365) begin
      case ($urandom_range(9))
        0: c = 11'd0;
        1: c = 11'd1;
        2: c = 11'd1024;
        3: c = 11'd2047;
        default: c = $urandom_range(1, 4);
      endcase
      case ($urandom_range(9))
        0: r = 7'd0;
        1: r = 7'd1;
        2: r = 7'd64;
        3: r = 7'd127;
        default: r = $urandom_range(1, 8);
      endcase
      er = (r == 0) ? 1 : (r > MaxRows) ? MaxRows : r;
      ec = (c == 0) ? 1 : (c > MaxCols) ? MaxCols : c;
      set_config($urandom_range(1), $urandom_range(1), c, r);
      // mostly whole images or columns, sometimes a broken run that ends mid-image
      if ($urandom_range(4) == 0) npix = $urandom_range(1, 20);
      else if (axis_q && er * ec <= 128) npix = er * ec;
      else npix = er * $urandom_range(1, (er > 8) ? 1 : 3);
      zero_img = ($urandom_range(4) == 0);
      for (int i = 0; i < npix; i++) begin
        smp = $urandom;
        if ($urandom_range(9) == 0) smp = $urandom_range(1) ? 16'h7fff : 16'h8000;
        wt = $urandom;
        case ($urandom_range(9))
          0: wt = '0;
          1: wt = 16'hffff;
          default: ;
        endcase
        if (zero_img) wt = '0;
        add_pixel(smp, wt);
      end
      total += npix;
    end

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("weighted_marginal_distribution_unit_test: PASS");
    end else begin
      $display("weighted_marginal_distribution_unit_test: FAIL");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("weighted_marginal_distribution_unit_test: FAIL");
    $finish;
  end

endmodule
